/* rtl/point_in_polygon_nearest_vertex_assert.svh */
// Assertion macros shared by the point-in-polygon block.
// Every use samples on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef POINT_IN_POLYGON_NEAREST_VERTEX_ASSERT_SVH
`define POINT_IN_POLYGON_NEAREST_VERTEX_ASSERT_SVH
`ifndef SYNTHESIS
`define PPNV_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ppnv assertion failed");
`define PPNV_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond |=> prop) \
        else $error("ppnv assertion failed");
`else
`define PPNV_ASSERT(label, prop)
`define PPNV_ASSERT_NEXT(label, cond, prop)
`endif
`endif

/* rtl/ppnv_pkg.sv */
package ppnv_pkg;

    // Coordinate and arithmetic widths.
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int DIST_W  = 50;
    localparam int CMP_W   = (SUM_W > DIST_W + 1) ? SUM_W : DIST_W + 1;

    // Work queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request type codes.
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_VERTEX = 1'b1;

    // Classification of a request by the front part.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_FIRST = 2'd1;
    localparam logic [1:0] KIND_NEXT  = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic        [DIST_W-1:0]  t_dist;

    localparam t_dist DIST_MAX = '1;

    // Operands of one edge test: the edge toggles when straddle and a*b < c*d.
    typedef struct packed {
        logic  straddle;
        t_diff a;
        t_diff b;
        t_diff c;
        t_diff d;
    } t_edge;

    // One classified request on its way to the back part.
    typedef struct packed {
        logic [1:0] kind;
        logic       last;
        t_edge      edge_a;
        t_edge      edge_b;
        t_diff      dx;
        t_diff      dy;
    } t_work;

    // Crossing test of edge (xi,yi)-(xj,yj) against the test point (tx,ty),
    // with the division replaced by a cross-multiplied compare whose order
    // follows the sign of the edge's y extent.
    function automatic t_edge edge_ops(input t_coord xi, input t_coord yi,
                                       input t_coord xj, input t_coord yj,
                                       input t_coord tx, input t_coord ty);
        t_edge e;
        t_diff ddy;
        t_diff dxj;
        t_diff dtx;
        t_diff dty;
        ddy = t_diff'(yj) - t_diff'(yi);
        dxj = t_diff'(xj) - t_diff'(xi);
        dtx = t_diff'(tx) - t_diff'(xi);
        dty = t_diff'(ty) - t_diff'(yi);
        e.straddle = (yi > ty) != (yj > ty);
        if (ddy > t_diff'(0)) begin
            e.a = dtx;
            e.b = ddy;
            e.c = dxj;
            e.d = dty;
        end else begin
            e.a = dxj;
            e.b = dty;
            e.c = dtx;
            e.d = ddy;
        end
        return e;
    endfunction

endpackage

/* rtl/ppnv_in_if.sv */
interface ppnv_in_if;
    logic            valid;
    logic            ready;
    logic            req_type;
    ppnv_pkg::t_coord coord_x;
    ppnv_pkg::t_coord coord_y;
    logic            last_vertex;

    modport source (output valid, output req_type, output coord_x, output coord_y,
                    output last_vertex, input ready);
    modport sink (input valid, input req_type, input coord_x, input coord_y,
                  input last_vertex, output ready);
endinterface

/* rtl/ppnv_out_if.sv */
interface ppnv_out_if;
    logic            valid;
    logic            ready;
    logic            inside_res;
    ppnv_pkg::t_dist min_dist_sq;

    modport source (output valid, output inside_res, output min_dist_sq, input ready);
    modport sink (input valid, input inside_res, input min_dist_sq, output ready);
endinterface

/* rtl/ppnv_front.sv */
`include "point_in_polygon_nearest_vertex_assert.svh"

module ppnv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ppnv_in_if.sink           i_req,
    input  logic              i_full,
    output logic              o_push,
    output ppnv_pkg::t_work   o_push_data
);

    ppnv_pkg::t_coord r_tx;
    ppnv_pkg::t_coord r_ty;
    ppnv_pkg::t_coord r_first_x;
    ppnv_pkg::t_coord r_first_y;
    ppnv_pkg::t_coord r_prev_x;
    ppnv_pkg::t_coord r_prev_y;
    logic             r_have_first;

    logic             w_accept;
    logic             w_is_vertex;
    ppnv_pkg::t_coord w_fx;
    ppnv_pkg::t_coord w_fy;

    // Requests are taken whenever the queue has room.
    assign i_req.ready = !i_full;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_is_vertex = (i_req.req_type == ppnv_pkg::REQ_VERTEX);

    // The closing edge of a one-vertex polygon starts at the vertex itself.
    assign w_fx = r_have_first ? r_first_x : i_req.coord_x;
    assign w_fy = r_have_first ? r_first_y : i_req.coord_y;

    // Classify the request and prepare the operand differences.
    always_comb begin
        if (!w_is_vertex) begin
            o_push_data.kind = ppnv_pkg::KIND_START;
        end else if (r_have_first) begin
            o_push_data.kind = ppnv_pkg::KIND_NEXT;
        end else begin
            o_push_data.kind = ppnv_pkg::KIND_FIRST;
        end
        o_push_data.last   = w_is_vertex && i_req.last_vertex;
        o_push_data.edge_a = ppnv_pkg::edge_ops(i_req.coord_x, i_req.coord_y,
                                                r_prev_x, r_prev_y, r_tx, r_ty);
        o_push_data.edge_b = ppnv_pkg::edge_ops(w_fx, w_fy, i_req.coord_x,
                                                i_req.coord_y, r_tx, r_ty);
        o_push_data.dx = ppnv_pkg::t_diff'(i_req.coord_x) - ppnv_pkg::t_diff'(r_tx);
        o_push_data.dy = ppnv_pkg::t_diff'(i_req.coord_y) - ppnv_pkg::t_diff'(r_ty);
    end

    assign o_push = w_accept;

    // Test point, first and previous vertex tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx         <= '0;
            r_ty         <= '0;
            r_first_x    <= '0;
            r_first_y    <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_have_first <= 1'b0;
        end else if (w_accept) begin
            if (!w_is_vertex) begin
                r_tx         <= i_req.coord_x;
                r_ty         <= i_req.coord_y;
                r_have_first <= 1'b0;
            end else begin
                if (!r_have_first) begin
                    r_first_x <= i_req.coord_x;
                    r_first_y <= i_req.coord_y;
                end
                r_prev_x     <= i_req.coord_x;
                r_prev_y     <= i_req.coord_y;
                r_have_first <= !i_req.last_vertex;
            end
        end
    end

    // A final vertex always ends the polygon in progress.
    `PPNV_ASSERT_NEXT(a_last_clears_first, w_accept && w_is_vertex && i_req.last_vertex, !r_have_first)

endmodule

/* rtl/ppnv_queue.sv */
`include "point_in_polygon_nearest_vertex_assert.svh"

module ppnv_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppnv_pkg::t_work i_push_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output ppnv_pkg::t_work o_data
);

    ppnv_pkg::t_work                r_mem [ppnv_pkg::QUEUE_DEPTH];
    logic [ppnv_pkg::QPTR_W-1:0]    r_wptr;
    logic [ppnv_pkg::QPTR_W-1:0]    r_rptr;
    logic [ppnv_pkg::QCNT_W-1:0]    r_count;
    logic [ppnv_pkg::QCNT_W-1:0]    n_count;

    localparam logic [ppnv_pkg::QPTR_W-1:0] LAST_PTR = ppnv_pkg::QPTR_W'(ppnv_pkg::QUEUE_DEPTH - 1);

    assign o_full  = (r_count == ppnv_pkg::QCNT_W'(ppnv_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    // Occupancy after this cycle's push and pop.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // A push alone grows the queue by one entry.
    `PPNV_ASSERT_NEXT(a_push_grows, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

/* rtl/ppnv_back.sv */
`include "point_in_polygon_nearest_vertex_assert.svh"

module ppnv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ppnv_pkg::t_work i_data,
    output logic            o_pop,
    ppnv_out_if.source      o_res
);

    // Stage 1: products.
    logic                r_s1_v;
    logic [1:0]          r_s1_kind;
    logic                r_s1_last;
    logic                r_s1_stra;
    logic                r_s1_strb;
    ppnv_pkg::t_prod     r_pa_l;
    ppnv_pkg::t_prod     r_pa_r;
    ppnv_pkg::t_prod     r_pb_l;
    ppnv_pkg::t_prod     r_pb_r;
    ppnv_pkg::t_prod     r_pdx;
    ppnv_pkg::t_prod     r_pdy;

    // Stage 2: crossing flags and saturated distance.
    logic                r_s2_v;
    logic [1:0]          r_s2_kind;
    logic                r_s2_last;
    logic                r_s2_tga;
    logic                r_s2_tgb;
    ppnv_pkg::t_dist     r_s2_dist;

    // Polygon state and result register.
    logic                r_parity;
    ppnv_pkg::t_dist     r_best;
    logic                r_out_v;
    logic                r_out_inside;
    ppnv_pkg::t_dist     r_out_dist;

    logic                w_en;
    logic                w_load;
    logic [ppnv_pkg::SUM_W-1:0] w_sum;
    logic [ppnv_pkg::CMP_W-1:0] w_sum_ext;
    ppnv_pkg::t_dist     w_dist;
    logic                n_parity;
    logic                w_par_res;
    ppnv_pkg::t_dist     n_best;

    // The pipeline moves whenever the result register can take a new value.
    assign w_en  = !r_out_v || o_res.ready;
    assign o_pop = w_en && i_valid;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_kind <= i_data.kind;
            r_s1_last <= i_data.last;
            r_s1_stra <= i_data.edge_a.straddle;
            r_s1_strb <= i_data.edge_b.straddle;
            r_pa_l    <= i_data.edge_a.a * i_data.edge_a.b;
            r_pa_r    <= i_data.edge_a.c * i_data.edge_a.d;
            r_pb_l    <= i_data.edge_b.a * i_data.edge_b.b;
            r_pb_r    <= i_data.edge_b.c * i_data.edge_b.d;
            r_pdx     <= i_data.dx * i_data.dx;
            r_pdy     <= i_data.dy * i_data.dy;
        end
    end

    // Squared distance, clipped to the result width.
    assign w_sum     = {1'b0, r_pdx} + {1'b0, r_pdy};
    assign w_sum_ext = ppnv_pkg::CMP_W'(w_sum);
    assign w_dist    = (w_sum_ext > ppnv_pkg::CMP_W'(ppnv_pkg::DIST_MAX)) ?
                       ppnv_pkg::DIST_MAX : w_sum_ext[ppnv_pkg::DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_kind <= r_s1_kind;
            r_s2_last <= r_s1_last;
            r_s2_tga  <= r_s1_stra && (r_pa_l < r_pa_r);
            r_s2_tgb  <= r_s1_strb && (r_pb_l < r_pb_r);
            r_s2_dist <= w_dist;
        end
    end

    // Parity and nearest-vertex update for the item leaving stage 2.
    always_comb begin
        case (r_s2_kind)
            ppnv_pkg::KIND_START: begin
                w_par_res = 1'b0;
                n_best    = '0;
            end
            ppnv_pkg::KIND_FIRST: begin
                w_par_res = r_s2_last && r_s2_tgb;
                n_best    = r_s2_dist;
            end
            ppnv_pkg::KIND_NEXT: begin
                w_par_res = r_parity ^ r_s2_tga ^ (r_s2_last && r_s2_tgb);
                n_best    = (r_s2_dist < r_best) ? r_s2_dist : r_best;
            end
            default: begin
                w_par_res = r_parity;
                n_best    = r_best;
            end
        endcase
        n_parity = r_s2_last ? 1'b0 : w_par_res;
        w_load   = w_en && r_s2_v && r_s2_last && (r_s2_kind != ppnv_pkg::KIND_START);
    end

    // Valid chain, polygon state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_parity <= 1'b0;
            r_best   <= '0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_en) begin
                r_s1_v <= i_valid;
                r_s2_v <= r_s1_v;
                if (r_s2_v) begin
                    r_parity <= n_parity;
                    r_best   <= n_best;
                end
            end
            if (w_load) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_inside <= w_par_res;
            r_out_dist   <= n_best;
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.inside_res  = r_out_inside;
    assign o_res.min_dist_sq = r_out_dist;

    // A finished polygon leaves the parity cleared.
    `PPNV_ASSERT_NEXT(a_parity_cleared, w_load, !r_parity)
    // While the result stalls, the item in stage 2 stays put.
    `PPNV_ASSERT_NEXT(a_stall_holds, !w_en && r_s2_v, r_s2_v && $stable(r_s2_kind))
    // A new result is loaded only when the register is free or being emptied.
    `PPNV_ASSERT(a_no_overwrite, !(w_load && r_out_v && !o_res.ready))

endmodule

/* rtl/point_in_polygon_nearest_vertex.sv */
// A final vertex goes through the queue, stage 1 and stage 2 into the result register.
// Throughput: one request per cycle while the queue has room; every unit works on a
// different request. A stalled result holds the multiply/compare pipeline; the
// 4-entry queue keeps taking requests until it is full.
// Reset is synchronous, active low, and clears test point, vertices, parity and distance.
module point_in_polygon_nearest_vertex (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ppnv_in_if.sink    i_req,
    ppnv_out_if.source o_res
);

    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_q_valid;
    ppnv_pkg::t_work w_push_data;
    ppnv_pkg::t_work w_q_data;

    // Accept and classify requests.
    ppnv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Decoupling queue.
    ppnv_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data)
    );

    // Products, crossing parity and nearest vertex.
    ppnv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_data  (w_q_data),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule
